// ----- design/rmsr_pkg.sv -----
// rmsr_pkg: shared types and constants for the reversing motor speed ramp
// used by rmsr_csr, rmsr_step and reversing_motor_speed_ramp_unit
package rmsr_pkg;

   localparam int DUTY_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [DUTY_WIDTH-1:0] DUTY_STOP_CW  = 8'h00;
   localparam logic [DUTY_WIDTH-1:0] DUTY_STOP_CCW = 8'hFF;
   localparam logic [DUTY_WIDTH-1:0] STEP_RESET    = 8'd5;
   localparam logic [DUTY_WIDTH-1:0] STEP_MIN      = 8'd1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TARGET_DIRECTION = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TARGET_SPEED     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RAMP_STEP        = 2'd2;

   localparam logic DIR_CW  = 1'b0;
   localparam logic DIR_CCW = 1'b1;

   typedef struct packed {
      logic                  target_direction;
      logic [DUTY_WIDTH-1:0] target_speed;
      logic [DUTY_WIDTH-1:0] ramp_step;
   } cfg_type;

   typedef struct packed {
      logic [DUTY_WIDTH-1:0] duty;
      logic                  dir;
   } motor_state_type;

endpackage

// ----- design/rmsr_csr.sv -----
// rmsr_csr: configuration register file for the speed ramp
// depends on rmsr_pkg
module rmsr_csr
   import rmsr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_TARGET_DIRECTION: cfg_in.target_direction = csr_wdata[0];
            REG_TARGET_SPEED:     cfg_in.target_speed     = csr_wdata[DUTY_WIDTH-1:0];
            REG_RAMP_STEP:        cfg_in.ramp_step        = csr_wdata[DUTY_WIDTH-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_direction <= DIR_CW;
         cfg_ff.target_speed     <= '0;
         cfg_ff.ramp_step        <= STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/rmsr_step.sv -----
// rmsr_step: one ramp update of duty and direction per tick
// depends on rmsr_pkg
module rmsr_step
   import rmsr_pkg::*;
(
   input  cfg_type         cfg,
   input  motor_state_type cur,
   input  logic            tick,
   output motor_state_type nxt,
   output logic            reached
);

   logic [DUTY_WIDTH-1:0] step;
   logic [DUTY_WIDTH-1:0] stop_level;
   logic [DUTY_WIDTH-1:0] goal;
   logic [DUTY_WIDTH-1:0] target;
   logic [DUTY_WIDTH-1:0] gap;
   logic [DUTY_WIDTH-1:0] move;
   logic [DUTY_WIDTH-1:0] ramped;
   logic                  reversing;

   assign step       = (cfg.ramp_step == '0) ? STEP_MIN : cfg.ramp_step;
   assign reversing  = (cur.dir != cfg.target_direction);
   assign stop_level = cur.dir ? DUTY_STOP_CCW : DUTY_STOP_CW;
   assign goal       = cur.dir ? (DUTY_STOP_CCW - cfg.target_speed) : cfg.target_speed;
   assign target     = reversing ? stop_level : goal;

   // clamped step toward target, never overshooting
   assign gap    = (cur.duty < target) ? (target - cur.duty) : (cur.duty - target);
   assign move   = (gap < step) ? gap : step;
   assign ramped = (cur.duty < target) ? (cur.duty + move) : (cur.duty - move);

   always_comb begin
      nxt     = cur;
      reached = 1'b0;
      if (tick) begin
         if (reversing && (cur.duty == stop_level)) begin
            nxt.dir  = ~cur.dir;
            nxt.duty = cur.dir ? DUTY_STOP_CW : DUTY_STOP_CCW;
         end else if (!reversing && (cur.duty == goal)) begin
            reached = 1'b1;
         end else begin
            nxt.duty = ramped;
         end
      end
   end

endmodule

// ----- design/reversing_motor_speed_ramp_unit.sv -----
// reversing_motor_speed_ramp_unit: top level of the motor speed ramp
// depends on rmsr_pkg, rmsr_csr and rmsr_step
//
// Each transfer with req_tick high moves the stored PWM duty toward the target
// speed by at most ramp_step, landing exactly on the goal. Counter-clockwise
// duty is inverted (255 is stopped). A direction change first ramps to the
// stopped level, then flips the direction on the following tick. One result
// transfer follows every tick transfer, registered and held until taken. A new
// tick is taken every cycle unless a result waits with rsp_ready low, and a
// tick is taken in the same cycle that a waiting result transfers.
module reversing_motor_speed_ramp_unit
   import rmsr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_tick,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [DUTY_WIDTH-1:0]      rsp_pwm_duty,
   output logic                       rsp_dir_level,
   output logic                       rsp_at_target,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type         cfg;
   motor_state_type state_ff;
   motor_state_type state_in;
   logic            reached;
   logic            req_xfer;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   motor_state_type rsp_state_ff;
   logic            rsp_at_target_ff;

   rmsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rmsr_step u_step (
      .cfg     (cfg),
      .cur     (state_ff),
      .tick    (req_tick),
      .nxt     (state_in),
      .reached (reached)
   );

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_xfer     = req_valid && req_ready;
   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.duty <= DUTY_STOP_CW;
         state_ff.dir  <= DIR_CW;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_state_ff     <= state_in;
         rsp_at_target_ff <= reached;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pwm_duty  = rsp_state_ff.duty;
   assign rsp_dir_level = rsp_state_ff.dir;
   assign rsp_at_target = rsp_at_target_ff;

endmodule

// ----- tb/sv/ramp_checker_pkg.sv -----
// ramp_checker_pkg: predictor and result checker for the motor speed ramp testbench
// depends on rmsr_pkg for widths, register indexes and stop levels
package ramp_checker_pkg;
   import rmsr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [DUTY_WIDTH-1:0] duty;
      logic                  dir;
      logic                  at_target;
   } ramp_output_type;

   class ramp_checker;
      logic                  tgt_dir;
      logic [DUTY_WIDTH-1:0] tgt_speed;
      logic [DUTY_WIDTH-1:0] step_cfg;
      logic [DUTY_WIDTH-1:0] duty;
      logic                  dir;
      ramp_output_type       pending_outputs[$];
      int                    errors;

      function new();
         tgt_dir   = DIR_CW;
         tgt_speed = '0;
         step_cfg  = STEP_RESET;
         duty      = DUTY_STOP_CW;
         dir       = DIR_CW;
         errors    = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
         case (idx)
            REG_TARGET_DIRECTION: tgt_dir = data[0];
            REG_TARGET_SPEED:     tgt_speed = data;
            REG_RAMP_STEP:        step_cfg = data;
            default: ;
         endcase
      endfunction

      function logic [DUTY_WIDTH-1:0] approach(logic [DUTY_WIDTH-1:0] cur,
                                               logic [DUTY_WIDTH-1:0] goal,
                                               logic [DUTY_WIDTH-1:0] step);
         logic [DUTY_WIDTH-1:0] diff;
         if (cur < goal) begin
            diff = goal - cur;
            return cur + ((diff < step) ? diff : step);
         end
         diff = cur - goal;
         return cur - ((diff < step) ? diff : step);
      endfunction

      function void take_tick(logic tick);
         ramp_output_type       r;
         logic [DUTY_WIDTH-1:0] step;
         logic [DUTY_WIDTH-1:0] stop;
         logic [DUTY_WIDTH-1:0] goal;
         step = (step_cfg == '0) ? STEP_MIN : step_cfg;
         r.at_target = 1'b0;
         if (tick) begin
            if (dir != tgt_dir) begin
               stop = dir ? DUTY_STOP_CCW : DUTY_STOP_CW;
               if (duty != stop) begin
                  duty = approach(duty, stop, step);
               end else begin
                  dir  = ~dir;
                  duty = dir ? DUTY_STOP_CCW : DUTY_STOP_CW;
               end
            end else begin
               goal = dir ? DUTY_STOP_CCW - tgt_speed : tgt_speed;
               if (duty == goal) r.at_target = 1'b1;
               else duty = approach(duty, goal, step);
            end
         end
         r.duty = duty;
         r.dir  = dir;
         pending_outputs.push_back(r);
      endfunction

      function void check_output(logic [DUTY_WIDTH-1:0] act_duty, logic act_dir, logic act_at);
         ramp_output_type e;
         if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected result transfer duty=%0d dir=%0b at_target=%0b",
                     $time, act_duty, act_dir, act_at);
            errors++;
            return;
         end
         e = pending_outputs.pop_front();
         if (act_duty !== e.duty) begin
            $display("%0t: pwm_duty mismatch expected %0d actual %0d", $time, e.duty, act_duty);
            errors++;
         end
         if (act_dir !== e.dir) begin
            $display("%0t: dir_level mismatch expected %0b actual %0b", $time, e.dir, act_dir);
            errors++;
         end
         if (act_at !== e.at_target) begin
            $display("%0t: at_target mismatch expected %0b actual %0b",
                     $time, e.at_target, act_at);
            errors++;
         end
      endfunction

      function int pending();
         return pending_outputs.size();
      endfunction
   endclass

endpackage

// ----- tb/sv/tb_reversing_motor_speed_ramp_unit.sv -----
// tb_reversing_motor_speed_ramp_unit: directed and random tick stimulus with csr phases
// depends on rmsr_pkg, ramp_checker_pkg and reversing_motor_speed_ramp_unit
module tb_reversing_motor_speed_ramp_unit;
   import rmsr_pkg::*;
   import ramp_checker_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_tick = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [DUTY_WIDTH-1:0]      rsp_pwm_duty;
   logic                       rsp_dir_level;
   logic                       rsp_at_target;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   int cycle_count = 0;
   int send_idle_pct = 33;
   int recv_idle_pct = 73;
   ramp_checker checker_h = new();

   reversing_motor_speed_ramp_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_tick(req_tick),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pwm_duty(rsp_pwm_duty), .rsp_dir_level(rsp_dir_level),
      .rsp_at_target(rsp_at_target),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   // result checked before the tick of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            checker_h.check_output(rsp_pwm_duty, rsp_dir_level, rsp_at_target);
         if (req_valid && req_ready)
            checker_h.take_tick(req_tick);
      end
   end

   task automatic send_tick(logic tick);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_tick  <= 1'($urandom_range(1, 0));
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tick  <= tick;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (checker_h.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      checker_h.write_reg(idx, data);
   endtask

   task automatic apply_settings(logic dir, logic [DUTY_WIDTH-1:0] speed,
                                 logic [DUTY_WIDTH-1:0] step);
      logic [CSR_DATA_WIDTH-1:0] dir_word;
      dir_word    = CSR_DATA_WIDTH'($urandom);
      dir_word[0] = dir;
      csr_write(REG_TARGET_DIRECTION, dir_word);
      csr_write(REG_TARGET_SPEED, speed);
      csr_write(REG_RAMP_STEP, step);
      if ($urandom_range(3, 0) == 0) csr_write(REG_UNUSED, CSR_DATA_WIDTH'($urandom));
      csr_we <= 1'b0;
   endtask

   task automatic random_settings();
      logic [DUTY_WIDTH-1:0] speed;
      logic [DUTY_WIDTH-1:0] step;
      case ($urandom_range(3, 0))
         0:       speed = '0;
         1:       speed = 8'hFF;
         default: speed = DUTY_WIDTH'($urandom);
      endcase
      case ($urandom_range(5, 0))
         0:       step = '0;
         1:       step = 8'd1;
         2:       step = 8'hFF;
         3, 4:    step = DUTY_WIDTH'($urandom_range(16, 2));
         default: step = DUTY_WIDTH'($urandom);
      endcase
      apply_settings(1'($urandom_range(1, 0)), speed, step);
   endtask

   initial begin
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, tick low, full swing both ways, zero step
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_drained();
      apply_settings(DIR_CW, 8'hFF, 8'hFF);
      repeat (2) send_tick(1'b1);
      wait_drained();
      csr_write(REG_UNUSED, 8'hA5);
      apply_settings(DIR_CCW, 8'hFF, 8'hFF);
      repeat (4) send_tick(1'b1);
      send_tick(1'b0);
      wait_drained();
      apply_settings(DIR_CCW, 8'd253, 8'd0);
      repeat (3) send_tick(1'b1);
      wait_drained();
      apply_settings(DIR_CW, 8'd0, 8'd100);
      repeat (5) send_tick(1'b1);
      wait_drained();
      apply_settings(DIR_CW, 8'd7, 8'd3);
      repeat (4) send_tick(1'b1);

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle_pct = 33; recv_idle_pct = 73; end
            1: begin send_idle_pct = 73; recv_idle_pct = 33; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int ph = 0; ph < 11; ph++) begin
            wait_drained();
            random_settings();
            n = $urandom_range(50, 30);
            for (int i = 0; i < n; i++) begin
               if (i == n / 2 && (ph == 0 || $urandom_range(3, 0) == 0))
                  wait_drained();
               send_tick($urandom_range(9, 0) != 0);
            end
         end
      end

      wait_drained();
      repeat (5) @(posedge clock);
      if (checker_h.errors == 0 && checker_h.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/rmsr_pkg.sv
design/rmsr_csr.sv
design/rmsr_step.sv
design/reversing_motor_speed_ramp_unit.sv
tb/sv/ramp_checker_pkg.sv
tb/sv/tb_reversing_motor_speed_ramp_unit.sv
